// ===== src/c16rx_pkg.sv =====
// ----------------------------------------------------------------------------
// c16rx_pkg
// Types, codes and the CRC-16 byte update shared by the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package c16rx_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd1;

  localparam logic        WIDE_LENGTH_RST   = 1'b0;
  localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd255;

  // header sizes, narrow and wide length field
  localparam logic [15:0] HDR_LEN_NARROW = 16'd4;
  localparam logic [15:0] HDR_LEN_WIDE   = 16'd5;

  // CRC-16, poly x^16 + x^15 + x^2 + 1, MSB first
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // request kinds
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame types
  localparam logic [2:0] FT_OK    = 3'd0;
  localparam logic [2:0] FT_ER    = 3'd1;
  localparam logic [2:0] FT_WT    = 3'd2;
  localparam logic [2:0] FT_NP    = 3'd3;
  localparam logic [2:0] FT_OTHER = 3'd4;

  // frame status
  localparam logic [2:0] ST_GOOD    = 3'd0;
  localparam logic [2:0] ST_CRC     = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_BAD_LEN = 3'd3;
  localparam logic [2:0] ST_NP_HDR  = 3'd4;

  // ASCII type letters
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_P = 8'h50;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_type;
    logic [7:0]  package_number;
    logic [15:0] frame_length;
    logic [7:0]  acked_package;
    logic [2:0]  frame_status;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] decode_type(input logic [7:0] t1, input logic [7:0] t2);
    logic [2:0] ft;
    if (t1 == CH_O && t2 == CH_K) begin
      ft = FT_OK;
    end else if (t1 == CH_E && t2 == CH_R) begin
      ft = FT_ER;
    end else if (t1 == CH_W && t2 == CH_T) begin
      ft = FT_WT;
    end else if (t1 == CH_N && t2 == CH_P) begin
      ft = FT_NP;
    end else begin
      ft = FT_OTHER;
    end
    return ft;
  endfunction

endpackage

`default_nettype wire

// ===== src/c16rx_in_if.sv =====
// ----------------------------------------------------------------------------
// c16rx_in_if
// Receive channel: serial bytes and timeout events.
// ----------------------------------------------------------------------------
`default_nettype none

interface c16rx_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/c16rx_out_if.sv =====
// ----------------------------------------------------------------------------
// c16rx_out_if
// Result channel: payload bytes and end-of-frame status.
// ----------------------------------------------------------------------------
`default_nettype none

interface c16rx_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_type;
  logic [7:0]  package_number;
  logic [15:0] frame_length;
  logic [7:0]  acked_package;
  logic [2:0]  frame_status;

  modport source (output valid, output out_kind, output payload_byte, output frame_type,
                  output package_number, output frame_length, output acked_package,
                  output frame_status, input ready);
  modport sink   (input valid, input out_kind, input payload_byte, input frame_type,
                  input package_number, input frame_length, input acked_package,
                  input frame_status, output ready);
endinterface

`default_nettype wire

// ===== src/c16rx_cfg_if.sv =====
// ----------------------------------------------------------------------------
// c16rx_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface c16rx_cfg_if import c16rx_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/crc16_response_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// crc16_response_frame_receiver_top
// Response frame deframer with CRC-16 (poly 0x8005, init 0) check.
//
// The block takes one item per clock unless stalled: a received byte or a timeout
// event. It parses type letters, package number and a one- or two-byte big-endian
// length (header plus payload), forwards each payload byte as a registered result,
// and closes the frame with a status result after the CRC low byte, on a timeout,
// or as soon as the length is found out of range. Each item is handled by the
// byte-wide CRC update and the frame counters as it is taken; results pass through
// a two-entry output buffer, so input stalls only when both entries are full.
// Write configuration only between frames.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_response_frame_receiver_top import c16rx_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  c16rx_in_if.sink      in_ch,
  c16rx_out_if.source   out_ch,
  c16rx_cfg_if.sink     cfg_ch
);

  // configuration
  logic        wide_r;
  logic [15:0] max_len_r;

  // frame state
  logic [15:0] cnt_r,   cnt_nxt;
  logic [15:0] exp_r,   exp_nxt;
  logic [15:0] crc_r,   crc_nxt;
  logic [7:0]  tf_r,    tf_nxt;
  logic [7:0]  ts_r,    ts_nxt;
  logic [7:0]  pkg_r,   pkg_nxt;
  logic [7:0]  prev_r,  prev_nxt;
  logic [7:0]  crch_r,  crch_nxt;

  // output buffer
  logic        out_valid_r;
  logic        skid_valid_r;
  res_t        out_r;
  res_t        skid_r;

  logic        accept;
  logic        pop;
  logic        has_res;
  res_t        res;
  logic [15:0] hl;
  logic [15:0] got;
  logic [2:0]  st;
  logic        clear;

  assign in_ch.ready  = !skid_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && !skid_valid_r;
  assign pop          = out_valid_r && out_ch.ready;
  assign hl           = wide_r ? HDR_LEN_WIDE : HDR_LEN_NARROW;
  assign got          = {crch_r, in_ch.rx_byte};

  always_comb begin
    cnt_nxt  = cnt_r;
    exp_nxt  = exp_r;
    crc_nxt  = crc_r;
    tf_nxt   = tf_r;
    ts_nxt   = ts_r;
    pkg_nxt  = pkg_r;
    prev_nxt = prev_r;
    crch_nxt = crch_r;
    has_res  = 1'b0;
    res      = '0;
    clear    = 1'b0;
    st       = ST_GOOD;
    if (accept) begin
      if (in_ch.req_type == REQ_TIMEOUT) begin
        has_res = 1'b1;
        clear   = 1'b1;
        res     = '{KIND_STATUS, 8'h00, decode_type(tf_r, ts_r), pkg_r, exp_r, prev_r,
                    ST_TIMEOUT};
      end else if (cnt_r == 16'd0 && exp_r != 16'd0) begin
        // CRC low byte closes the frame
        if (got != crc_r) begin
          st = ST_CRC;
        end else if (decode_type(tf_r, ts_r) == FT_NP && pkg_r != 8'h00) begin
          st = ST_NP_HDR;
        end
        has_res = 1'b1;
        clear   = 1'b1;
        res     = '{KIND_STATUS, 8'h00, decode_type(tf_r, ts_r), pkg_r, exp_r, prev_r, st};
      end else if (cnt_r < hl) begin
        case (cnt_r[2:0])
          3'd0:    tf_nxt  = in_ch.rx_byte;
          3'd1:    ts_nxt  = in_ch.rx_byte;
          3'd2:    pkg_nxt = in_ch.rx_byte;
          3'd3:    exp_nxt = wide_r ? {in_ch.rx_byte, 8'h00} : {8'h00, in_ch.rx_byte};
          default: exp_nxt = {exp_r[7:0], in_ch.rx_byte};
        endcase
        crc_nxt  = crc16_byte(crc_r, in_ch.rx_byte);
        prev_nxt = in_ch.rx_byte;
        cnt_nxt  = cnt_r + 16'd1;
        if (cnt_nxt == hl && (exp_nxt < hl || exp_nxt > max_len_r)) begin
          has_res = 1'b1;
          clear   = 1'b1;
          res     = '{KIND_STATUS, 8'h00, decode_type(tf_nxt, ts_nxt), pkg_nxt, exp_nxt,
                      prev_nxt, ST_BAD_LEN};
        end
      end else if (exp_r < hl || exp_r > max_len_r) begin
        // length went out of range through a register change: drop the byte
        has_res = 1'b1;
        clear   = 1'b1;
        res     = '{KIND_STATUS, 8'h00, decode_type(tf_r, ts_r), pkg_r, exp_r, prev_r,
                    ST_BAD_LEN};
      end else if (cnt_r < exp_r) begin
        crc_nxt  = crc16_byte(crc_r, in_ch.rx_byte);
        prev_nxt = in_ch.rx_byte;
        cnt_nxt  = cnt_r + 16'd1;
        has_res  = 1'b1;
        res      = '{KIND_PAYLOAD, in_ch.rx_byte, FT_OK, 8'h00, 16'h0000, 8'h00, ST_GOOD};
      end else begin
        // CRC high byte; wait for the low byte with the count at zero
        crch_nxt = in_ch.rx_byte;
        cnt_nxt  = 16'd0;
      end
    end
    if (clear) begin
      cnt_nxt  = '0;
      exp_nxt  = '0;
      crc_nxt  = '0;
      tf_nxt   = '0;
      ts_nxt   = '0;
      pkg_nxt  = '0;
      prev_nxt = '0;
      crch_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r    <= WIDE_LENGTH_RST;
      max_len_r <= MAX_FRAME_LEN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_WIDE_LENGTH:   wide_r    <= cfg_ch.data[0];
        CFG_MAX_FRAME_LEN: max_len_r <= cfg_ch.data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      exp_r  <= '0;
      crc_r  <= '0;
      tf_r   <= '0;
      ts_r   <= '0;
      pkg_r  <= '0;
      prev_r <= '0;
      crch_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      exp_r  <= exp_nxt;
      crc_r  <= crc_nxt;
      tf_r   <= tf_nxt;
      ts_r   <= ts_nxt;
      pkg_r  <= pkg_nxt;
      prev_r <= prev_nxt;
      crch_r <= crch_nxt;
    end
  end

  // two-entry output buffer: the skid entry fills only when the head is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (has_res) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (has_res) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_kind       = out_r.out_kind;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.frame_type     = out_r.frame_type;
  assign out_ch.package_number = out_r.package_number;
  assign out_ch.frame_length   = out_r.frame_length;
  assign out_ch.acked_package  = out_r.acked_package;
  assign out_ch.frame_status   = out_r.frame_status;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty head");

  a_timeout_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.req_type == REQ_TIMEOUT) |=> (cnt_r == 16'd0 && exp_r == 16'd0))
    else $error("timeout did not return the receiver to idle");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= HDR_LEN_WIDE || cnt_r <= exp_r))
    else $error("byte count ran past the frame length");

  a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (has_res && out_valid_r && !out_ch.ready) |=> (skid_valid_r && out_valid_r))
    else $error("result lost while output stalled");

endmodule

`default_nettype wire

// ===== verif/crc16_response_frame_receiver_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_response_frame_receiver_top_tb
// Sends received bytes and timeout events into the response frame receiver.
// A transaction-level model of the deframer in this bench works out the payload
// and end-of-frame items that each byte should produce, and every item the
// block hands out is compared field by field, in order. A short table of hand
// written frames comes first. Random frames follow under several length
// modes and length limits, with random gaps on both sides and one long output
// hold-off that backs the block up.
// ----------------------------------------------------------------------------

module crc16_response_frame_receiver_top_tb;
  import c16rx_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned N_PHASES        = 6;
  localparam int unsigned PRESSURE_PHASE  = 4;

  // where a table row takes its byte from
  typedef enum logic [1:0] {SRC_LIT, SRC_CRC_HI, SRC_CRC_LO, SRC_CRC_LO_BAD} byte_src_t;

  typedef struct packed {
    logic       rt;
    logic [7:0] b;
    byte_src_t  src;
    logic       typed;
    res_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  c16rx_in_if  in_ch();
  c16rx_out_if out_ch();
  c16rx_cfg_if cfg_ch();

  crc16_response_frame_receiver_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // deframer model: configuration and frame state
  logic        wide_mode;
  logic [15:0] max_len;
  logic [15:0] rx_count;
  logic [15:0] len_field;
  logic [15:0] crc_acc;
  logic [7:0]  letter_a;
  logic [7:0]  letter_b;
  logic [7:0]  pkg_no;
  logic [7:0]  last_byte;
  logic [7:0]  crc_hi;

  res_t        frame_results[$];
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          hold_req;
  bit          holding;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] acc;
    acc = c ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) begin
      acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [2:0] type_of(input logic [7:0] a, input logic [7:0] b);
    case ({a, b})
      {CH_O, CH_K}: return FT_OK;
      {CH_E, CH_R}: return FT_ER;
      {CH_W, CH_T}: return FT_WT;
      {CH_N, CH_P}: return FT_NP;
      default:      return FT_OTHER;
    endcase
  endfunction

  function automatic void clear_frame();
    rx_count  = '0;
    len_field = '0;
    crc_acc   = '0;
    letter_a  = '0;
    letter_b  = '0;
    pkg_no    = '0;
    last_byte = '0;
    crc_hi    = '0;
  endfunction

  function automatic res_t close_frame(input logic [2:0] st);
    res_t r;
    r                = '0;
    r.out_kind       = KIND_STATUS;
    r.frame_type     = type_of(letter_a, letter_b);
    r.package_number = pkg_no;
    r.frame_length   = len_field;
    r.acked_package  = last_byte;
    r.frame_status   = st;
    clear_frame();
    return r;
  endfunction

  function automatic bit len_out_of_range(input logic [15:0] hl);
    return (len_field < hl) || (len_field > max_len);
  endfunction

  // advance the model by one accepted item; returns 1 when an item is due out
  function automatic bit predict_item(input logic rt, input logic [7:0] b, output res_t r);
    logic [15:0] hl;
    r  = '0;
    hl = wide_mode ? HDR_LEN_WIDE : HDR_LEN_NARROW;
    if (rt == REQ_TIMEOUT) begin
      r = close_frame(ST_TIMEOUT);
      return 1'b1;
    end
    // CRC low byte closes the frame
    if (rx_count == 16'd0 && len_field != 16'd0) begin
      if ({crc_hi, b} != crc_acc) begin
        r = close_frame(ST_CRC);
      end else if (letter_a == CH_N && letter_b == CH_P && pkg_no != 8'h00) begin
        r = close_frame(ST_NP_HDR);
      end else begin
        r = close_frame(ST_GOOD);
      end
      return 1'b1;
    end
    if (rx_count < hl) begin
      case (rx_count)
        16'd0:   letter_a = b;
        16'd1:   letter_b = b;
        16'd2:   pkg_no = b;
        16'd3:   len_field = wide_mode ? {b, 8'h00} : {8'h00, b};
        default: len_field = {len_field[7:0], b};
      endcase
      crc_acc   = crc_step(crc_acc, b);
      last_byte = b;
      rx_count  = rx_count + 16'd1;
      if (rx_count == hl && len_out_of_range(hl)) begin
        r = close_frame(ST_BAD_LEN);
        return 1'b1;
      end
      return 1'b0;
    end
    if (len_out_of_range(hl)) begin
      r = close_frame(ST_BAD_LEN);
      return 1'b1;
    end
    if (rx_count < len_field) begin
      crc_acc        = crc_step(crc_acc, b);
      last_byte      = b;
      rx_count       = rx_count + 16'd1;
      r.out_kind     = KIND_PAYLOAD;
      r.payload_byte = b;
      return 1'b1;
    end
    // CRC high byte: hold it and wait for the low byte
    crc_hi   = b;
    rx_count = '0;
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_item(input logic rt, input logic [7:0] b,
                           input logic typed = 1'b0, input res_t want = '0);
    res_t r;
    bit   has;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= rt;
    in_ch.rx_byte  <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    has = predict_item(rt, b, r);
    if (typed) begin
      frame_results.push_back(want);
    end else if (has) begin
      frame_results.push_back(r);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_WIDE_LENGTH) begin
      wide_mode = data[0];
    end else if (idx == CFG_MAX_FRAME_LEN) begin
      max_len = data;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering items and wait until the block has nothing left in flight
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame();
    logic [7:0]  body[$];
    logic [7:0]  t1;
    logic [7:0]  t2;
    logic [7:0]  pkg;
    logic [15:0] crc_word;
    int          hl;
    int          cap;
    int          top;
    int          len;
    int          shape;
    int          cut;
    int          n_body;
    bit          good;
    bit          bad_crc;
    // abort whatever partial frame the noise left behind
    if (rx_count != 16'd0 || len_field != 16'd0) begin
      send_item(REQ_TIMEOUT, 8'($urandom_range(255)));
    end
    case ($urandom_range(5))
      0:       begin t1 = CH_O; t2 = CH_K; end
      1:       begin t1 = CH_E; t2 = CH_R; end
      2:       begin t1 = CH_W; t2 = CH_T; end
      3, 4:    begin t1 = CH_N; t2 = CH_P; end
      default: begin t1 = 8'($urandom_range(255)); t2 = 8'($urandom_range(255)); end
    endcase
    pkg = (t1 == CH_N && t2 == CH_P && $urandom_range(3) != 0) ? 8'h00
                                                               : 8'($urandom_range(255));
    hl  = wide_mode ? 5 : 4;
    cap = wide_mode ? 65535 : 255;
    top = (max_len < cap) ? max_len : cap;
    shape = $urandom_range(99);
    if (shape < 8) begin
      len = $urandom_range(hl - 1, 0);
    end else if (shape < 14 && top < cap) begin
      len = $urandom_range((top + 20 < cap) ? top + 20 : cap, top + 1);
    end else begin
      len = hl + (($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(6));
      if (top >= hl && len > top) len = top;
    end
    good = (len >= hl) && (len <= max_len);
    body.push_back(t1);
    body.push_back(t2);
    body.push_back(pkg);
    if (wide_mode) body.push_back(len[15:8]);
    body.push_back(len[7:0]);
    if (good) begin
      for (int p = hl; p < len; p++) body.push_back(8'($urandom_range(255)));
    end
    n_body  = body.size();
    cut     = ($urandom_range(99) < 6) ? $urandom_range(n_body + 1) : -1;
    bad_crc = ($urandom_range(99) < 10);
    for (int i = 0; i < n_body + 2; i++) begin
      if (i == cut) begin
        send_item(REQ_TIMEOUT, 8'($urandom_range(255)));
        return;
      end
      if (i == n_body) begin
        if (!good) return;
        crc_word = crc_acc ^ (bad_crc ? 16'($urandom_range(65535, 1)) : 16'h0000);
      end
      if (i < n_body) begin
        send_item(REQ_BYTE, body[i]);
      end else begin
        send_item(REQ_BYTE, (i == n_body) ? crc_word[15:8] : crc_word[7:0]);
      end
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready <= !holding && ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin : hold_off
    wait (hold_req);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.out_kind, out_ch.payload_byte, out_ch.frame_type, out_ch.package_number,
             out_ch.frame_length, out_ch.acked_package, out_ch.frame_status};
      if (frame_results.size() == 0) begin
        $error("unexpected item: out_kind %0d payload_byte %0h", got.out_kind, got.payload_byte);
        mismatches++;
      end else begin
        want = frame_results.pop_front();
        check_field("out_kind", 16'(want.out_kind), 16'(got.out_kind));
        check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
        check_field("frame_type", 16'(want.frame_type), 16'(got.frame_type));
        check_field("package_number", 16'(want.package_number), 16'(got.package_number));
        check_field("frame_length", want.frame_length, got.frame_length);
        check_field("acked_package", 16'(want.acked_package), 16'(got.acked_package));
        check_field("frame_status", 16'(want.frame_status), 16'(got.frame_status));
      end
    end
  end

  initial begin : stimulus
    stim_row_t   dir_rows[$];
    logic [7:0]  b;
    logic [15:0] limit;
    int unsigned phase_end;

    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_BYTE;
    in_ch.rx_byte  = 8'h00;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_WIDE_LENGTH;
    cfg_ch.data    = 16'h0000;
    out_ch.ready   = 1'b0;
    hold_req       = 1'b0;
    holding        = 1'b0;
    src_idle_pct   = 6;
    sink_idle_pct  = 74;
    wide_mode      = WIDE_LENGTH_RST;
    max_len        = MAX_FRAME_LEN_RST;
    clear_frame();
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    dir_rows = '{
      // timeout while idle reports an empty frame
      '{REQ_TIMEOUT, 8'hFF, SRC_LIT, 1'b1,
        '{KIND_STATUS, 8'h00, FT_OTHER, 8'h00, 16'd0, 8'h00, ST_TIMEOUT}},
      '{REQ_BYTE, CH_O, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, CH_K, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h00, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h06, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h00, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'hFF, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h00, SRC_CRC_HI, 1'b0, '0},
      '{REQ_BYTE, 8'h00, SRC_CRC_LO, 1'b0, '0},
      // header-only frame with a corrupted CRC
      '{REQ_BYTE, CH_E, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, CH_R, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h01, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h04, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h00, SRC_CRC_HI, 1'b0, '0},
      '{REQ_BYTE, 8'h00, SRC_CRC_LO_BAD, 1'b1,
        '{KIND_STATUS, 8'h00, FT_ER, 8'h01, 16'd4, 8'h04, ST_CRC}},
      // NP with a nonzero package number and a good CRC
      '{REQ_BYTE, CH_N, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, CH_P, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'hFF, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h04, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h00, SRC_CRC_HI, 1'b0, '0},
      '{REQ_BYTE, 8'h00, SRC_CRC_LO, 1'b1,
        '{KIND_STATUS, 8'h00, FT_NP, 8'hFF, 16'd4, 8'h04, ST_NP_HDR}},
      // length shorter than the header
      '{REQ_BYTE, CH_W, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, CH_T, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h07, SRC_LIT, 1'b0, '0},
      '{REQ_BYTE, 8'h03, SRC_LIT, 1'b1,
        '{KIND_STATUS, 8'h00, FT_WT, 8'h07, 16'd3, 8'h03, ST_BAD_LEN}},
      // timeout part way through the type letters
      '{REQ_BYTE, CH_O, SRC_LIT, 1'b0, '0},
      '{REQ_TIMEOUT, 8'h00, SRC_LIT, 1'b1,
        '{KIND_STATUS, 8'h00, FT_OTHER, 8'h00, 16'd0, CH_O, ST_TIMEOUT}}
    };

    foreach (dir_rows[i]) begin
      case (dir_rows[i].src)
        SRC_CRC_HI:     b = crc_acc[15:8];
        SRC_CRC_LO:     b = crc_acc[7:0];
        SRC_CRC_LO_BAD: b = crc_acc[7:0] ^ 8'h01;
        default:        b = dir_rows[i].b;
      endcase
      send_item(dir_rows[i].rt, b, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain();
      case (phase)
        0:       begin write_reg(CFG_WIDE_LENGTH, 16'd1); limit = 16'hFFFF; end
        1:       begin write_reg(CFG_WIDE_LENGTH, 16'd0); limit = 16'd6; end
        2:       begin write_reg(CFG_WIDE_LENGTH, 16'd0); limit = 16'd255; end
        3:       begin write_reg(CFG_WIDE_LENGTH, 16'd1); limit = 16'd6; end
        4:       begin
          write_reg(CFG_WIDE_LENGTH, 16'd1);
          limit = 16'($urandom_range(300, 7));
        end
        // limit between zero and five, around the narrow header length
        default: begin write_reg(CFG_WIDE_LENGTH, 16'd0); limit = 16'($urandom_range(5)); end
      endcase
      write_reg(CFG_MAX_FRAME_LEN, limit);
      if (phase < 2) begin
        src_idle_pct  = 6;
        sink_idle_pct = 74;
      end else if (phase < 4) begin
        src_idle_pct  = 74;
        sink_idle_pct = 6;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (phase == PRESSURE_PHASE) hold_req = 1'b1;
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 10) begin
          repeat ($urandom_range(6, 1)) begin
            send_item(($urandom_range(3) == 0) ? REQ_TIMEOUT : REQ_BYTE,
                      8'($urandom_range(255)));
          end
        end else begin
          send_frame();
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/c16rx_pkg.sv
src/c16rx_in_if.sv
src/c16rx_out_if.sv
src/c16rx_cfg_if.sv
src/crc16_response_frame_receiver_top.sv
verif/crc16_response_frame_receiver_top_tb.sv
